@@ rtl/tfd_pkg.sv @@
`default_nettype none

package tfd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 5;
  localparam int unsigned PayloadLen = 11;

  // frame layout
  localparam logic [CountW-1:0] TypeOff      = 5'd4;
  localparam logic [CountW-1:0] PayloadFirst = 5'd5;
  localparam logic [CountW-1:0] PayloadLast  = 5'd15;
  localparam logic [CountW-1:0] TailEOff     = 5'd18;
  localparam logic [CountW-1:0] TailNOff     = 5'd19;
  localparam logic [CountW-1:0] LastOff      = 5'd20;

  // marker bytes
  localparam logic [ByteW-1:0] SyncByte = 8'h7E;
  localparam logic [ByteW-1:0] TypeByte = 8'h01;
  localparam logic [ByteW-1:0] TailE    = 8'h45;
  localparam logic [ByteW-1:0] TailN    = 8'h4E;
  localparam logic [ByteW-1:0] TailD    = 8'h44;

  typedef logic [PayloadLen-1:0][ByteW-1:0] payload_t;

  // one finished frame as it travels from the front to the back
  typedef struct packed {
    logic     good;
    payload_t payload;
  } frame_t;

  // push request and queue full status passed from the front to the queue
  typedef struct packed {
    logic full;
    logic push;
  } q_ctl_t;

endpackage

`default_nettype wire

@@ rtl/tfd_front.sv @@
`default_nettype none

module tfd_front
  import tfd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rx_valid_i,
  output logic                  rx_stall_o,
  input  wire logic [ByteW-1:0] rx_byte_i,
  input  wire logic             q_full_i,
  output q_ctl_t                q_ctl_o,
  output frame_t                frame_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              first_sync_q, first_sync_d;
  logic              type_ok_q, type_ok_d;
  logic              tail_e_q, tail_e_d;
  logic              tail_n_q, tail_n_d;
  payload_t          payload_q;
  logic              accept;
  logic              is_sync;
  logic [CountW-1:0] pay_off;
  logic              in_payload;

  assign rx_stall_o = q_full_i;
  assign accept     = rx_valid_i & ~q_full_i;
  assign is_sync    = (rx_byte_i == SyncByte);
  assign pay_off    = count_q - PayloadFirst;
  assign in_payload = (count_q >= PayloadFirst) && (count_q <= PayloadLast);

  // byte count and running checks
  always_comb begin
    count_d      = count_q;
    first_sync_d = first_sync_q;
    type_ok_d    = type_ok_q;
    tail_e_d     = tail_e_q;
    tail_n_d     = tail_n_q;
    if (accept) begin
      priority if (count_q == '0) begin
        first_sync_d = is_sync;
        count_d      = 5'd1;
      end else if (count_q == 5'd1) begin
        // slide the header window by one byte when the pair is not 7E 7E
        if (first_sync_q && is_sync) begin
          count_d = 5'd2;
        end else begin
          first_sync_d = is_sync;
          count_d      = 5'd1;
        end
      end else if (count_q >= LastOff) begin
        count_d = '0;
      end else begin
        count_d = count_q + 5'd1;
        if (count_q == TypeOff)  type_ok_d = (rx_byte_i == TypeByte);
        if (count_q == TailEOff) tail_e_d  = (rx_byte_i == TailE);
        if (count_q == TailNOff) tail_n_d  = (rx_byte_i == TailN);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      first_sync_q <= 1'b0;
      type_ok_q    <= 1'b0;
      tail_e_q     <= 1'b0;
      tail_n_q     <= 1'b0;
    end else begin
      count_q      <= count_d;
      first_sync_q <= first_sync_d;
      type_ok_q    <= type_ok_d;
      tail_e_q     <= tail_e_d;
      tail_n_q     <= tail_n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_payload) begin
      payload_q[pay_off[3:0]] <= rx_byte_i;
    end
  end

  assign q_ctl_o.full  = q_full_i;
  assign q_ctl_o.push  = accept && (count_q >= LastOff);
  assign frame_o.good  = type_ok_q & tail_e_q & tail_n_q & (rx_byte_i == TailD);
  assign frame_o.payload = payload_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LastOff)
    else $error("byte count beyond frame length");

  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctl_o.push |=> count_q == '0)
    else $error("count not cleared after a complete frame");

endmodule

`default_nettype wire

@@ rtl/tfd_queue.sv @@
`default_nettype none

module tfd_queue
  import tfd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire q_ctl_t ctl_i,
  input  wire frame_t wr_data_i,
  output logic        full_o,
  output logic        rd_valid_o,
  input  wire logic   pop_i,
  output frame_t      rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  frame_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign rd_valid_o = (cnt_q != '0);
  assign do_push    = ctl_i.push;
  assign do_pop     = pop_i & rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wr_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> !ctl_i.full && !full_o)
    else $error("push into a full queue");

endmodule

`default_nettype wire

@@ rtl/tfd_back.sv @@
`default_nettype none

module tfd_back
  import tfd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_valid_i,
  input  wire frame_t q_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output logic        good_o,
  output payload_t    payload_o
);

  logic     out_valid_q, out_valid_d;
  logic     good_q;
  payload_t payload_q;

  assign pop_o       = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_d = pop_o | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // bad frames report an all-zero payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      good_q    <= q_data_i.good;
      payload_q <= q_data_i.good ? q_data_i.payload : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign good_o      = good_q;
  assign payload_o   = payload_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !good_q |-> payload_q == '0)
    else $error("bad frame carries a nonzero payload");

endmodule

`default_nettype wire

@@ rtl/telemetry_frame_deframer.sv @@
// a result passes from its 21st accepted byte through the frame queue into the output register
// throughput: one byte per cycle unless stalled; a result every 21 bytes at most
// rx_stall_o rises only while the frame queue is full (QueueDepth results held)
// reset: rst_ni async active low, clears byte count, queue pointers and output valid
// payload registers are not reset; they are always written before use
`default_nettype none

module telemetry_frame_deframer
  import tfd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // byte request channel
  input  wire logic             rx_valid_i,
  output logic                  rx_stall_o,
  input  wire logic [ByteW-1:0] rx_byte_i,
  // frame result channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  frame_good_o,
  output logic [ByteW-1:0]      group_reg_one_o,
  output logic [ByteW-1:0]      group_reg_two_o,
  output logic [ByteW-1:0]      group_reg_three_o,
  output logic [ByteW-1:0]      group_reg_four_o,
  output logic [ByteW-1:0]      group_reg_five_o,
  output logic [ByteW-1:0]      status_word_one_o,
  output logic [ByteW-1:0]      status_word_two_o,
  output logic [ByteW-1:0]      reread_bit_errors_o,
  output logic [ByteW-1:0]      reread_total_errors_o,
  output logic [ByteW-1:0]      work_status_o,
  output logic [ByteW-1:0]      device_status_o
);

  // front: header sync, byte count, running type/trailer checks, payload capture
  // queue: holds finished frames so the front keeps taking bytes under output stall until it fills
  // back: output register, masks the payload of bad frames

  q_ctl_t   q_ctl;
  frame_t   front_frame;
  frame_t   q_frame;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  payload_t payload;

  tfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_ctl_o    (q_ctl),
    .frame_o    (front_frame)
  );

  tfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (q_ctl),
    .wr_data_i  (front_frame),
    .full_o     (q_full),
    .rd_valid_o (q_valid),
    .pop_i      (q_pop),
    .rd_data_o  (q_frame)
  );

  tfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_frame),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .good_o      (frame_good_o),
    .payload_o   (payload)
  );

  // payload slot k holds frame offset 5 + k
  assign group_reg_one_o       = payload[0];
  assign group_reg_two_o       = payload[1];
  assign group_reg_three_o     = payload[2];
  assign group_reg_four_o      = payload[3];
  assign group_reg_five_o      = payload[4];
  assign status_word_one_o     = payload[5];
  assign status_word_two_o     = payload[6];
  assign reread_bit_errors_o   = payload[7];
  assign reread_total_errors_o = payload[8];
  assign work_status_o         = payload[9];
  assign device_status_o       = payload[10];

endmodule

`default_nettype wire
